// ===== rtl/asin_pkg.sv =====
// ----------------------------------------------------------------------------
// asin_pkg
// Shared types and codes for the arcsin series evaluator: sequencer states,
// arithmetic unit opcodes and request struct, status codes, register map.
// ----------------------------------------------------------------------------
package asin_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_MULX,
        S_MULK,
        S_DIVK,
        S_DIVT,
        S_ACC,
        S_EMIT
    } state_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_LIMIT  = 2'd2;

    localparam int          ADDR_W      = 2;
    localparam logic [1:0]  REG_EPSILON = 2'd0;
    localparam logic [23:0] EPS_RESET   = 24'd256;

endpackage

// ===== rtl/asin_alu.sv =====
// ----------------------------------------------------------------------------
// asin_alu
// Shared bit-serial arithmetic unit: msb-first shift-add multiply and
// restoring divide, one bit per cycle, for a programmable number of steps.
// ----------------------------------------------------------------------------
module asin_alu #(
    parameter int  W  = 24,
    parameter int  KW = 8,
    localparam int CW = $clog2(W + 1),
    localparam int PW = 2 * W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  asin_pkg::alu_req_t req,
    input  logic [W-1:0]       opa,
    input  logic [W-1:0]       opb,
    input  logic [KW-1:0]      rem_init,
    input  logic [KW-1:0]      dvs,
    input  logic [CW-1:0]      count,
    output logic               done,
    output logic [PW-1:0]      acc,
    output logic [W-1:0]       sh
);

    asin_pkg::alu_op_t op_reg, op_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     cmax_reg, cmax_next;
    logic [W-1:0]      opa_reg, opa_next;
    logic [KW-1:0]     dvs_reg, dvs_next;
    logic [PW-1:0]     acc_reg, acc_next;
    logic [W-1:0]      sh_reg, sh_next;
    logic [KW:0]       trial;
    logic [KW:0]       diff;

    assign trial = {acc_reg[KW-1:0], sh_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        op_next   = op_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        cmax_next = cmax_reg;
        opa_next  = opa_reg;
        dvs_next  = dvs_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        if (req.start)
        begin
            op_next   = req.op;
            run_next  = 1'b1;
            cnt_next  = '0;
            cmax_next = count;
            opa_next  = opa;
            dvs_next  = dvs;
            sh_next   = opb;
            acc_next  = (req.op == asin_pkg::ALU_MUL) ? '0 : PW'(rem_init);
        end
        else if (run_reg)
        begin
            unique case (op_reg)
                asin_pkg::ALU_MUL:
                begin
                    acc_next = (acc_reg << 1) + (sh_reg[W-1] ? PW'(opa_reg) : '0);
                    sh_next  = sh_reg << 1;
                end
                asin_pkg::ALU_DIV:
                begin
                    // restoring step: quotient bit enters at the lsb
                    if (!diff[KW])
                    begin
                        acc_next = PW'(diff[KW-1:0]);
                        sh_next  = {sh_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = PW'(trial[KW-1:0]);
                        sh_next  = {sh_reg[W-2:0], 1'b0};
                    end
                end
            endcase
            cnt_next = CW'(cnt_reg + 1'b1);
            if (CW'(cnt_reg + 1'b1) == cmax_reg)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= asin_pkg::ALU_MUL;
            cnt_reg  <= '0;
            cmax_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            cmax_reg <= cmax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg <= opa_next;
        dvs_reg <= dvs_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign sh   = sh_reg;

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("alu done while still running");

endmodule

// ===== rtl/arcsin_series_evaluator.sv =====
// ----------------------------------------------------------------------------
// arcsin_series_evaluator
// Each request squares |x|, then runs MULX, MULK, DIVK, DIVT and ACC once per series
// term until epsilon or the term limit stops it, then EMIT; KW = clog2(2*MAX_TERMS+2).
// Throughput: one request at a time; the shared bit-serial mul/div unit sets it.
// Rejected arguments return in the cycle after the request. Results cannot stall.
// Reset clears the sequencer and sets epsilon to 256.
// ----------------------------------------------------------------------------
module arcsin_series_evaluator #(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [23:0]          x_value,
    output logic                        done,
    output logic signed [25:0]          arcsin_value,
    output logic [6:0]                  terms_used,
    output logic [1:0]                  status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [asin_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int W   = FRAC_BITS;
    localparam int KW  = $clog2(2 * MAX_TERMS + 2);
    localparam int KCW = $clog2(MAX_TERMS + 1);
    localparam int CW  = $clog2(W + 1);

    asin_pkg::state_t   state_reg, state_next;
    logic               run_reg, run_next;
    logic [23:0]        eps_reg, eps_next;
    logic [KCW-1:0]     k_reg, k_next;
    logic [W-1:0]       q_reg, q_next;
    logic [W-1:0]       x2_reg, x2_next;
    logic [W-1:0]       t_reg, t_next;
    logic [W:0]         sum_reg, sum_next;
    logic               neg_reg, neg_next;
    logic signed [25:0] res_reg, res_next;
    logic [6:0]         terms_reg, terms_next;
    logic [1:0]         status_reg, status_next;

    asin_pkg::alu_req_t alu_req;
    logic [W-1:0]       alu_opa, alu_opb;
    logic [KW-1:0]      alu_rem, alu_dvs;
    logic [CW-1:0]      alu_count;
    logic               alu_done;
    logic [2*W-1:0]     alu_acc;
    logic [W-1:0]       alu_sh;

    logic               accept;
    logic               cfg_write;
    logic [23:0]        mag24;
    logic               reject;
    logic [W-1:0]       a_mag;
    logic [W-1:0]       e_mag;
    logic [W:0]         sum_acc;
    logic [24:0]        sum_q24;
    logic               is_op_state;
    logic               stop_ok;
    logic               stop_limit;
    logic [KW-1:0]      even_k, odd_lo, odd_hi;

    assign accept    = start && !busy;
    assign busy      = (state_reg != asin_pkg::S_IDLE);
    assign done      = (state_reg == asin_pkg::S_EMIT);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == asin_pkg::REG_EPSILON) ? {8'd0, eps_reg} : 32'd0;

    assign mag24  = x_value[23] ? 24'(-x_value) : 24'(x_value);
    assign reject = mag24[23] || (eps_reg == 24'd0);

    // move |x| from q.23 and epsilon from q0.24 into the internal scale
    generate
        if (W >= 23)
        begin : g_a_up
            assign a_mag = W'(mag24[22:0]) << (W - 23);
        end
        else
        begin : g_a_dn
            assign a_mag = W'(mag24[22:0] >> (23 - W));
        end
        if (W >= 24)
        begin : g_e_up
            assign e_mag = W'(eps_reg) << (W - 24);
        end
        else
        begin : g_e_dn
            assign e_mag = W'(eps_reg >> (24 - W));
        end
        if (W >= 24)
        begin : g_s_dn
            assign sum_q24 = 25'(sum_acc >> (W - 24));
        end
        else
        begin : g_s_up
            assign sum_q24 = 25'(sum_acc) << (24 - W);
        end
    endgenerate

    assign sum_acc    = sum_reg + (W + 1)'(t_reg);
    assign even_k     = KW'({k_reg, 1'b0});
    assign odd_lo     = even_k - KW'(1);
    assign odd_hi     = even_k + KW'(1);
    assign stop_ok    = (t_reg <= e_mag);
    assign stop_limit = (k_reg == KCW'(MAX_TERMS));

    assign is_op_state = (state_reg == asin_pkg::S_SQR)  || (state_reg == asin_pkg::S_MULX)
                      || (state_reg == asin_pkg::S_MULK) || (state_reg == asin_pkg::S_DIVK)
                      || (state_reg == asin_pkg::S_DIVT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asin_pkg::S_IDLE:
                if (accept)
                    state_next = reject ? asin_pkg::S_EMIT : asin_pkg::S_SQR;
            asin_pkg::S_SQR:
                if (alu_done)
                    state_next = asin_pkg::S_MULX;
            asin_pkg::S_MULX:
                if (alu_done)
                    state_next = asin_pkg::S_MULK;
            asin_pkg::S_MULK:
                if (alu_done)
                    state_next = asin_pkg::S_DIVK;
            asin_pkg::S_DIVK:
                if (alu_done)
                    state_next = asin_pkg::S_DIVT;
            asin_pkg::S_DIVT:
                if (alu_done)
                    state_next = asin_pkg::S_ACC;
            asin_pkg::S_ACC:
                state_next = (stop_ok || stop_limit) ? asin_pkg::S_EMIT : asin_pkg::S_MULX;
            asin_pkg::S_EMIT:
                state_next = asin_pkg::S_IDLE;
        endcase
    end

    // unit launch and operand select
    always_comb
    begin
        alu_req.start = is_op_state && !run_reg;
        alu_req.op    = asin_pkg::ALU_MUL;
        alu_opa       = q_reg;
        alu_opb       = q_reg;
        alu_rem       = '0;
        alu_dvs       = odd_hi;
        alu_count     = CW'(W);
        unique case (state_reg)
            asin_pkg::S_SQR:
            begin
                alu_opb = q_reg;
            end
            asin_pkg::S_MULX:
            begin
                alu_opb = x2_reg;
            end
            asin_pkg::S_MULK:
            begin
                // multiplier left-aligned so only its KW bits are stepped
                alu_opb   = W'(odd_lo) << (W - KW);
                alu_count = CW'(KW);
            end
            asin_pkg::S_DIVK:
            begin
                alu_req.op = asin_pkg::ALU_DIV;
                alu_rem    = alu_acc[W+KW-1:W];
                alu_opb    = alu_acc[W-1:0];
                alu_dvs    = even_k;
            end
            asin_pkg::S_DIVT:
            begin
                alu_req.op = asin_pkg::ALU_DIV;
                alu_opb    = q_reg;
                alu_dvs    = odd_hi;
            end
            asin_pkg::S_IDLE, asin_pkg::S_ACC, asin_pkg::S_EMIT:
            begin
                alu_opb = q_reg;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        run_next    = run_reg;
        eps_next    = eps_reg;
        k_next      = k_reg;
        q_next      = q_reg;
        x2_next     = x2_reg;
        t_next      = t_reg;
        sum_next    = sum_reg;
        neg_next    = neg_reg;
        res_next    = res_reg;
        terms_next  = terms_reg;
        status_next = status_reg;

        if (alu_req.start)
            run_next = 1'b1;
        else if (alu_done)
            run_next = 1'b0;

        if (cfg_write && (paddr == asin_pkg::REG_EPSILON))
            eps_next = pwdata[23:0];

        unique case (state_reg)
            asin_pkg::S_IDLE:
                if (accept)
                begin
                    if (reject)
                    begin
                        res_next    = '0;
                        terms_next  = '0;
                        status_next = asin_pkg::ST_REJECT;
                    end
                    else
                    begin
                        q_next   = a_mag;
                        sum_next = (W + 1)'(a_mag);
                        neg_next = x_value[23];
                        k_next   = KCW'(1);
                    end
                end
            asin_pkg::S_SQR:
                if (alu_done)
                    x2_next = alu_acc[2*W-1:W];
            asin_pkg::S_MULX:
                if (alu_done)
                    q_next = alu_acc[2*W-1:W];
            asin_pkg::S_DIVK:
                if (alu_done)
                    q_next = alu_sh;
            asin_pkg::S_DIVT:
                if (alu_done)
                    t_next = alu_sh;
            asin_pkg::S_ACC:
            begin
                sum_next   = sum_acc;
                terms_next = (32'(k_reg) > 127) ? 7'd127 : 7'(k_reg);
                res_next   = neg_reg ? -$signed(26'(sum_q24)) : $signed(26'(sum_q24));
                if (stop_ok)
                    status_next = asin_pkg::ST_OK;
                else if (stop_limit)
                    status_next = asin_pkg::ST_LIMIT;
                else
                    k_next = KCW'(k_reg + 1'b1);
            end
            asin_pkg::S_MULK, asin_pkg::S_EMIT:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asin_pkg::S_IDLE;
            run_reg   <= 1'b0;
            eps_reg   <= asin_pkg::EPS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            eps_reg   <= eps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        q_reg      <= q_next;
        x2_reg     <= x2_next;
        t_reg      <= t_next;
        sum_reg    <= sum_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
        terms_reg  <= terms_next;
        status_reg <= status_next;
    end

    asin_alu #(
        .W  (W),
        .KW (KW)
    ) u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (alu_req),
        .opa      (alu_opa),
        .opb      (alu_opb),
        .rem_init (alu_rem),
        .dvs      (alu_dvs),
        .count    (alu_count),
        .done     (alu_done),
        .acc      (alu_acc),
        .sh       (alu_sh)
    );

    assign arcsin_value = res_reg;
    assign terms_used   = terms_reg;
    assign status       = status_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request accepted but block not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == asin_pkg::ST_REJECT)) |-> ((arcsin_value == 26'sd0)
        && (terms_used == 7'd0)))
        else $error("rejected request with nonzero result");

    a_terms_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != asin_pkg::ST_REJECT)) |-> (terms_used != 7'd0))
        else $error("accepted argument reported no terms");

    a_alu_launched: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> run_reg)
        else $error("unit finished an operation that was never launched");

endmodule

// ===== tb/tb_arcsin_series_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arcsin_series_evaluator
// Drives signed Q1.23 arguments into the arcsin series evaluator and checks
// each result (sum, term count, status) against an in-bench fixed-point
// series calculation. Epsilon is reprogrammed over the APB port between
// phases; request gaps are randomized per request, or zero in some phases.
// ----------------------------------------------------------------------------
module tb_arcsin_series_evaluator;

    localparam int MAX_TERMS  = 64;
    localparam int FRAC_BITS  = 24;
    localparam int PERIOD     = 12;
    localparam int MAX_REPORT = 10;
    localparam int SETTLE     = 6000;

    typedef struct packed {
        logic [25:0] value;
        logic [6:0]  terms;
        logic [1:0]  status;
    } arcsin_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [23:0]          x_value = '0;
    logic                        done;
    logic signed [25:0]          arcsin_value;
    logic [6:0]                  terms_used;
    logic [1:0]                  status;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [asin_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    logic [23:0]                 argument_queue[$];
    arcsin_result_t              pending_arcsin[$];
    logic [23:0]                 epsilon_cfg = asin_pkg::EPS_RESET;
    int                          idle_left = 0;
    int                          max_gap = 5;
    int                          fault_count = 0;

    arcsin_series_evaluator #(
        .MAX_TERMS(MAX_TERMS),
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .x_value(x_value),
        .done(done),
        .arcsin_value(arcsin_value),
        .terms_used(terms_used),
        .status(status),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #(PERIOD / 2) clk = ~clk;
    end

    // move a magnitude between binary point positions, truncating when narrowing
    function automatic logic [63:0] shift_point(input logic [63:0] v, input int from_bits,
                                               input int to_bits);
        if (to_bits >= from_bits)
            return v << (to_bits - from_bits);
        return v >> (from_bits - to_bits);
    endfunction

    function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] product;
        product = {64'd0, a} * {64'd0, b};
        return product[63 + FRAC_BITS -: 64];
    endfunction

    function automatic arcsin_result_t arcsin_series(input logic [23:0] x,
                                                     input logic [23:0] eps);
        arcsin_result_t r;
        logic           neg;
        logic [24:0]    mag;
        logic [63:0]    a;
        logic [63:0]    e;
        logic [63:0]    x2;
        logic [63:0]    q;
        logic [63:0]    term;
        logic [63:0]    total;
        logic [63:0]    k;
        logic [63:0]    scaled;
        int             count;
        bit             met;
        neg = x[23];
        mag = neg ? (25'h1000000 - {1'b0, x}) : {1'b0, x};
        r.value  = '0;
        r.terms  = '0;
        r.status = asin_pkg::ST_REJECT;
        if (mag >= 25'h800000 || eps == 24'd0)
            return r;
        a     = shift_point({39'd0, mag}, 23, FRAC_BITS);
        e     = shift_point({40'd0, eps}, 24, FRAC_BITS);
        x2    = frac_mul(a, a);
        q     = a;
        total = a;
        count = 0;
        met   = 1'b0;
        for (k = 64'd1; k <= MAX_TERMS && !met; k++)
        begin
            q     = frac_mul(q, x2);
            q     = (q * (2 * k - 1)) / (2 * k);
            term  = q / (2 * k + 1);
            total = total + term;
            count = int'(k);
            met   = (term <= e);
        end
        scaled = shift_point(total, FRAC_BITS, 24);
        if (neg)
            scaled = 64'd0 - scaled;
        r.value  = scaled[25:0];
        r.terms  = (count > 127) ? 7'd127 : count[6:0];
        r.status = met ? asin_pkg::ST_OK : asin_pkg::ST_LIMIT;
        return r;
    endfunction

    // request driver: a slot opens when start is low or the request was just taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                pending_arcsin.push_back(arcsin_series(x_value, epsilon_cfg));
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                    start     <= 1'b0;
                end
                else if (argument_queue.size() != 0)
                begin
                    x_value   <= argument_queue.pop_front();
                    start     <= 1'b1;
                    idle_left <= int'($urandom_range(0, max_gap));
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        arcsin_result_t want;
        if (rst_n && done)
        begin
            if (pending_arcsin.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORT)
                    $display("%0t: result with no request pending: %0d %0d %0d",
                             $realtime, arcsin_value, terms_used, status);
            end
            else
            begin
                want = pending_arcsin.pop_front();
                if (arcsin_value !== want.value || terms_used !== want.terms ||
                    status !== want.status)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORT)
                        $display("%0t: mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 $realtime, $signed(want.value), want.terms, want.status,
                                 arcsin_value, terms_used, status);
                end
            end
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (argument_queue.size() != 0 || start || pending_arcsin.size() != 0)
            @(negedge clk);
    endtask

    task automatic load_epsilon(input logic [31:0] word);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= asin_pkg::REG_EPSILON;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        epsilon_cfg = word[23:0];
    endtask

    function automatic logic [23:0] random_argument();
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = 24'($urandom());
            3, 4:    v = 24'($urandom_range(0, 24'h000FFF) << $urandom_range(0, 11));
            5, 6:    v = 24'($urandom_range(24'h400000, 24'h7FFFFF));
            7:       v = 24'($urandom_range(24'h7FF000, 24'h7FFFFF));
            8:       v = 24'($urandom_range(0, 24'h0000FF));
            default: v = ($urandom_range(0, 3) == 0) ? 24'h800000 : 24'h7FFFFF;
        endcase
        // random sign for every draw but 24'h800000
        if ($urandom_range(0, 1) && v != 24'h800000)
            v = 24'd0 - v;
        return v;
    endfunction

    initial
    begin
        logic [23:0] eps;
        logic [31:0] word;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at the reset epsilon
        max_gap = 5;
        argument_queue = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800001,
                           24'h800000, 24'h400000, 24'hC00000, 24'h555555, 24'hAAAAAA,
                           24'h2AAAAA, 24'h7FF000, 24'h000100, 24'h3FFFFF};
        wait_idle();

        // zero epsilon is rejected like an out-of-range argument
        load_epsilon(32'd0);
        argument_queue = '{24'h400000, 24'h000000, 24'h800000};
        wait_idle();

        // tightest threshold drives long series and the term limit
        load_epsilon(32'd1);
        max_gap = 0;
        argument_queue = '{24'h7FFFFF, 24'h000001, 24'hE00000};
        wait_idle();

        load_epsilon(32'h00FFFFFF);
        argument_queue = '{24'h7FFFFF, 24'h800001, 24'h123456};
        wait_idle();

        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase % 5)
                0:       eps = 24'($urandom_range(1, 24'hFFFFFF));
                1:       eps = 24'($urandom_range(1, 4096));
                2:       eps = 24'd1 << $urandom_range(0, 23);
                3:       eps = (phase == 3) ? 24'd1 : 24'hFFFFFF;
                default: eps = 24'($urandom_range(24'h000100, 24'h00FFFF));
            endcase
            word = {8'($urandom()), eps};
            load_epsilon(word);
            max_gap = (phase % 2 == 1) ? 0 : 5;
            for (int n = 0; n < 27; n++)
                argument_queue.push_back(random_argument());
            wait_idle();
        end

        repeat (SETTLE) @(posedge clk);
        if (pending_arcsin.size() != 0)
        begin
            fault_count++;
            $display("%0d expected results never arrived", pending_arcsin.size());
        end
        if (fault_count == 0)
            $display("tb_arcsin_series_evaluator passed");
        else
            $display("tb_arcsin_series_evaluator failed");
        $finish;
    end

    initial
    begin
        #(64'd10_000_000 * PERIOD);
        $display("tb_arcsin_series_evaluator failed");
        $finish;
    end

endmodule

// ===== arcsin_series_evaluator.f =====
rtl/asin_pkg.sv
rtl/asin_alu.sv
rtl/arcsin_series_evaluator.sv
tb/tb_arcsin_series_evaluator.sv
